// ===== hw/rtl/vbf_pkg.sv =====
// Shared constants, types and the box-to-voxel range function of the voxel box fill grid.
package vbf_pkg;

    localparam int GRID_SIZE     = 32;
    localparam int GRID_BITS     = $clog2(GRID_SIZE);
    localparam int FRAC_BITS     = 8;
    localparam int ID_BITS       = 8;
    localparam int COORD_BITS    = 16;
    localparam int BOUND_BITS    = GRID_BITS + 2;
    localparam int MODE_BITS     = 2;
    localparam int ROWS          = GRID_SIZE * GRID_SIZE;
    localparam int ROW_ADDR_BITS = 2 * GRID_BITS;
    localparam int ROW_BITS      = GRID_SIZE * ID_BITS;
    localparam int SPAN_BITS     = COORD_BITS + 1 - FRAC_BITS;
    localparam int HALF          = 1 << (FRAC_BITS - 1);

    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd2;

    localparam logic signed [BOUND_BITS-1:0] BOUND_NONE_MIN = BOUND_BITS'(GRID_SIZE);
    localparam logic signed [BOUND_BITS-1:0] BOUND_NONE_MAX = '1;

    typedef struct packed {
        logic                 empty;
        logic [GRID_BITS-1:0] first;
        logic [GRID_BITS-1:0] last;
    } axis_t;

    typedef struct packed {
        logic                 idle;
        logic                 done;
        logic                 is_clear;
        logic                 is_add;
        logic [GRID_BITS-1:0] x_first;
        logic [GRID_BITS-1:0] x_last;
        logic [GRID_BITS-1:0] y_first;
        logic [GRID_BITS-1:0] y_last;
        logic [GRID_BITS-1:0] z_first;
        logic [GRID_BITS-1:0] z_last;
        logic [ID_BITS-1:0]   found_id;
    } vbf_status_t;

    // first = floor(lo + 0.5), last = ceil(hi + 0.5) - 1, both clipped to the grid.
    function automatic axis_t axis_range(logic signed [COORD_BITS-1:0] lo,
                                         logic signed [COORD_BITS-1:0] hi);
        logic signed [COORD_BITS:0]  lo_sum;
        logic signed [COORD_BITS:0]  hi_sum;
        logic signed [COORD_BITS:0]  lo_sh;
        logic signed [COORD_BITS:0]  hi_sh;
        logic signed [SPAN_BITS-1:0] s;
        logic signed [SPAN_BITS-1:0] t;
        axis_t                       r;
        lo_sum = $signed({lo[COORD_BITS-1], lo}) + $signed((COORD_BITS + 1)'(HALF));
        hi_sum = $signed({hi[COORD_BITS-1], hi}) + $signed((COORD_BITS + 1)'(HALF - 1));
        lo_sh  = lo_sum >>> FRAC_BITS;
        hi_sh  = hi_sum >>> FRAC_BITS;
        s      = lo_sh[SPAN_BITS-1:0];
        t      = hi_sh[SPAN_BITS-1:0];
        if (s < $signed(SPAN_BITS'(0)))
        begin
            s = '0;
        end
        if (t > $signed(SPAN_BITS'(GRID_SIZE - 1)))
        begin
            t = SPAN_BITS'(GRID_SIZE - 1);
        end
        r.empty = (s > t);
        r.first = s[GRID_BITS-1:0];
        r.last  = t[GRID_BITS-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/vbf_ctrl.sv =====
// Row memory of the voxel grid and the sequencer that clears, fills and reads it.
module vbf_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [vbf_pkg::MODE_BITS-1:0]         mode,
    input  logic signed [vbf_pkg::COORD_BITS-1:0] box_x_low,
    input  logic signed [vbf_pkg::COORD_BITS-1:0] box_x_high,
    input  logic signed [vbf_pkg::COORD_BITS-1:0] box_y_low,
    input  logic signed [vbf_pkg::COORD_BITS-1:0] box_y_high,
    input  logic signed [vbf_pkg::COORD_BITS-1:0] box_z_low,
    input  logic signed [vbf_pkg::COORD_BITS-1:0] box_z_high,
    input  logic [vbf_pkg::ID_BITS-1:0]           object_id,
    input  logic [vbf_pkg::GRID_BITS-1:0]         query_x,
    input  logic [vbf_pkg::GRID_BITS-1:0]         query_y,
    input  logic [vbf_pkg::GRID_BITS-1:0]         query_z,
    input  logic                                  ack,
    output vbf_pkg::vbf_status_t                  status
);
    import vbf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_LOOK   = 3'd3;
    localparam logic [2:0] ST_LWAIT  = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    localparam logic [ROW_ADDR_BITS-1:0] LAST_ROW = ROW_ADDR_BITS'(ROWS - 1);

    // One row holds all voxels along z for a given x and y.
    logic [ROW_BITS-1:0]      mem [ROWS];
    logic [ROW_BITS-1:0]      rd_row_reg;
    logic [ROW_BITS-1:0]      merged_row;
    logic [ID_BITS-1:0]       rd_cells [GRID_SIZE];
    logic                     rd_en;
    logic [ROW_ADDR_BITS-1:0] rd_addr;

    logic [2:0]               state_reg, state_next;
    logic                     respond_reg, respond_next;
    logic                     is_clear_reg, is_clear_next;
    logic                     is_add_reg, is_add_next;
    logic [GRID_BITS-1:0]     x_reg, x_next;
    logic [GRID_BITS-1:0]     y_reg, y_next;
    axis_t                    xr_reg, xr_next;
    axis_t                    yr_reg, yr_next;
    axis_t                    zr_reg, zr_next;
    logic [GRID_SIZE-1:0]     mask_reg, mask_next;
    logic [ID_BITS-1:0]       id_reg, id_next;
    logic [GRID_BITS-1:0]     qx_reg, qx_next;
    logic [GRID_BITS-1:0]     qy_reg, qy_next;
    logic [GRID_BITS-1:0]     qz_reg, qz_next;
    logic [ROW_ADDR_BITS-1:0] clr_row_reg, clr_row_next;
    logic                     wb_valid_reg, wb_valid_next;
    logic [ROW_ADDR_BITS-1:0] wb_addr_reg, wb_addr_next;
    logic [ID_BITS-1:0]       found_reg, found_next;

    axis_t                    ax, ay, az;
    logic [GRID_SIZE-1:0]     z_mask;

    assign ax = axis_range(box_x_low, box_x_high);
    assign ay = axis_range(box_y_low, box_y_high);
    assign az = axis_range(box_z_low, box_z_high);

    always_comb
    begin
        for (int z = 0; z < GRID_SIZE; z++)
        begin
            z_mask[z] = (GRID_BITS'(z) >= az.first) && (GRID_BITS'(z) <= az.last);
            rd_cells[z] = rd_row_reg[z*ID_BITS +: ID_BITS];
            merged_row[z*ID_BITS +: ID_BITS] = mask_reg[z] ? id_reg
                                               : rd_row_reg[z*ID_BITS +: ID_BITS];
        end
    end

    // The write of a row lands in the cycle after its read; rows inside one pass differ,
    // and the drain state keeps the next item from reading a row still in flight.
    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            mem[wb_addr_reg] <= merged_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        respond_next  = respond_reg;
        is_clear_next = is_clear_reg;
        is_add_next   = is_add_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        xr_next       = xr_reg;
        yr_next       = yr_reg;
        zr_next       = zr_reg;
        mask_next     = mask_reg;
        id_next       = id_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qz_next       = qz_reg;
        clr_row_next  = clr_row_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        found_next    = found_reg;
        rd_en         = 1'b0;
        rd_addr       = clr_row_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    respond_next  = 1'b1;
                    is_clear_next = 1'b0;
                    is_add_next   = 1'b0;
                    found_next    = '0;
                    xr_next       = ax;
                    yr_next       = ay;
                    zr_next       = az;
                    x_next        = ax.first;
                    y_next        = ay.first;
                    qx_next       = query_x;
                    qy_next       = query_y;
                    qz_next       = query_z;
                    case (mode)
                        MODE_CLEAR:
                        begin
                            is_clear_next = 1'b1;
                            clr_row_next  = '0;
                            mask_next     = '1;
                            id_next       = '0;
                            state_next    = ST_CLEAR;
                        end
                        MODE_ADD:
                        begin
                            if (!ax.empty && !ay.empty && !az.empty && object_id != '0)
                            begin
                                is_add_next = 1'b1;
                                mask_next   = z_mask;
                                id_next     = object_id;
                                state_next  = ST_FILL;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            state_next = ST_LOOK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                rd_en         = 1'b1;
                rd_addr       = clr_row_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = clr_row_reg;
                clr_row_next  = clr_row_reg + 1'b1;
                if (clr_row_reg == LAST_ROW)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_FILL:
            begin
                rd_en         = 1'b1;
                rd_addr       = {x_reg, y_reg};
                wb_valid_next = 1'b1;
                wb_addr_next  = {x_reg, y_reg};
                if (y_reg == yr_reg.last)
                begin
                    y_next = yr_reg.first;
                    if (x_reg == xr_reg.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end
            ST_LOOK:
            begin
                rd_en      = 1'b1;
                rd_addr    = {qx_reg, qy_reg};
                state_next = ST_LWAIT;
            end
            ST_LWAIT:
            begin
                found_next = rd_cells[qz_reg];
                state_next = ST_FINISH;
            end
            ST_DRAIN:
            begin
                state_next = respond_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reset starts a clearing pass that produces no result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            respond_reg  <= 1'b0;
            is_clear_reg <= 1'b0;
            is_add_reg   <= 1'b0;
            clr_row_reg  <= '0;
            wb_valid_reg <= 1'b0;
            mask_reg     <= '1;
            id_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            respond_reg  <= respond_next;
            is_clear_reg <= is_clear_next;
            is_add_reg   <= is_add_next;
            clr_row_reg  <= clr_row_next;
            wb_valid_reg <= wb_valid_next;
            mask_reg     <= mask_next;
            id_reg       <= id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        xr_reg      <= xr_next;
        yr_reg      <= yr_next;
        zr_reg      <= zr_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        qz_reg      <= qz_next;
        wb_addr_reg <= wb_addr_next;
        found_reg   <= found_next;
    end

    always_comb
    begin
        status.idle     = (state_reg == ST_IDLE);
        status.done     = (state_reg == ST_FINISH);
        status.is_clear = is_clear_reg;
        status.is_add   = is_add_reg;
        status.x_first  = xr_reg.first;
        status.x_last   = xr_reg.last;
        status.y_first  = yr_reg.first;
        status.y_last   = yr_reg.last;
        status.z_first  = zr_reg.first;
        status.z_last   = zr_reg.last;
        status.found_id = found_reg;
    end

endmodule

// ===== hw/rtl/voxel_box_fill_grid.sv =====
// Top level of the voxel box fill grid: handshakes, bounding box and result register.
//
//  Channel  | Handshake           | Beat contents
//  ---------+---------------------+---------------------------------------------------
//  in       | in_valid / in_ready | mode, box_{x,y,z}_{low,high}, object_id, query_*
//  out      | out_valid/out_ready | found_id, grid_empty, bound_{min,max}_{x,y,z}
//
// One item is worked at a time; the row memory (one row per x,y pair, 32 voxels along z)
// sets the time. Clear writes all 1024 rows, one row write per cycle.
// Add box goes over (x span * y span) rows, one row read-merge-write per cycle;
// an empty or clipped-away box writes no row. Lookup reads a single row.
// After reset a clearing pass runs with in_ready low.
// The next item is taken while the last result beat still waits; its own result then
// waits until that beat leaves.
module voxel_box_fill_grid (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [vbf_pkg::MODE_BITS-1:0]          mode,
    input  logic signed [vbf_pkg::COORD_BITS-1:0]  box_x_low,
    input  logic signed [vbf_pkg::COORD_BITS-1:0]  box_x_high,
    input  logic signed [vbf_pkg::COORD_BITS-1:0]  box_y_low,
    input  logic signed [vbf_pkg::COORD_BITS-1:0]  box_y_high,
    input  logic signed [vbf_pkg::COORD_BITS-1:0]  box_z_low,
    input  logic signed [vbf_pkg::COORD_BITS-1:0]  box_z_high,
    input  logic [vbf_pkg::ID_BITS-1:0]            object_id,
    input  logic [vbf_pkg::GRID_BITS-1:0]          query_x,
    input  logic [vbf_pkg::GRID_BITS-1:0]          query_y,
    input  logic [vbf_pkg::GRID_BITS-1:0]          query_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [vbf_pkg::ID_BITS-1:0]            found_id,
    output logic                                   grid_empty,
    output logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_min_x,
    output logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_max_x,
    output logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_min_y,
    output logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_max_y,
    output logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_min_z,
    output logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_max_z
);
    import vbf_pkg::*;

    vbf_status_t                   status;
    logic                          ack;
    logic                          out_valid_reg, out_valid_next;
    logic [ID_BITS-1:0]            found_reg, found_next;
    logic                          any_reg, any_next;
    logic signed [BOUND_BITS-1:0]  min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [BOUND_BITS-1:0]  min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic signed [BOUND_BITS-1:0]  min_z_reg, min_z_next, max_z_reg, max_z_next;
    logic signed [BOUND_BITS-1:0]  x_first, x_last, y_first, y_last, z_first, z_last;

    vbf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && in_ready),
        .mode       (mode),
        .box_x_low  (box_x_low),
        .box_x_high (box_x_high),
        .box_y_low  (box_y_low),
        .box_y_high (box_y_high),
        .box_z_low  (box_z_low),
        .box_z_high (box_z_high),
        .object_id  (object_id),
        .query_x    (query_x),
        .query_y    (query_y),
        .query_z    (query_z),
        .ack        (ack),
        .status     (status)
    );

    assign in_ready = status.idle;
    assign ack      = status.done && (!out_valid_reg || out_ready);

    assign x_first = $signed(BOUND_BITS'(status.x_first));
    assign x_last  = $signed(BOUND_BITS'(status.x_last));
    assign y_first = $signed(BOUND_BITS'(status.y_first));
    assign y_last  = $signed(BOUND_BITS'(status.y_last));
    assign z_first = $signed(BOUND_BITS'(status.z_first));
    assign z_last  = $signed(BOUND_BITS'(status.z_last));

    // The bounds only move at the edge where a new result beat is loaded, so they can
    // drive the result ports straight from their registers.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        any_next       = any_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        min_z_next     = min_z_reg;
        max_z_next     = max_z_reg;
        if (ack)
        begin
            out_valid_next = 1'b1;
            found_next     = status.found_id;
            if (status.is_clear)
            begin
                any_next   = 1'b0;
                min_x_next = BOUND_NONE_MIN;
                max_x_next = BOUND_NONE_MAX;
                min_y_next = BOUND_NONE_MIN;
                max_y_next = BOUND_NONE_MAX;
                min_z_next = BOUND_NONE_MIN;
                max_z_next = BOUND_NONE_MAX;
            end
            else if (status.is_add)
            begin
                any_next   = 1'b1;
                min_x_next = (x_first < min_x_reg) ? x_first : min_x_reg;
                max_x_next = (x_last > max_x_reg) ? x_last : max_x_reg;
                min_y_next = (y_first < min_y_reg) ? y_first : min_y_reg;
                max_y_next = (y_last > max_y_reg) ? y_last : max_y_reg;
                min_z_next = (z_first < min_z_reg) ? z_first : min_z_reg;
                max_z_next = (z_last > max_z_reg) ? z_last : max_z_reg;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            any_reg       <= 1'b0;
            min_x_reg     <= BOUND_NONE_MIN;
            max_x_reg     <= BOUND_NONE_MAX;
            min_y_reg     <= BOUND_NONE_MIN;
            max_y_reg     <= BOUND_NONE_MAX;
            min_z_reg     <= BOUND_NONE_MIN;
            max_z_reg     <= BOUND_NONE_MAX;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            any_reg       <= any_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            min_z_reg     <= min_z_next;
            max_z_reg     <= max_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
    end

    assign out_valid   = out_valid_reg;
    assign found_id    = found_reg;
    assign grid_empty  = !any_reg;
    assign bound_min_x = min_x_reg;
    assign bound_max_x = max_x_reg;
    assign bound_min_y = min_y_reg;
    assign bound_max_y = max_y_reg;
    assign bound_min_z = min_z_reg;
    assign bound_max_z = max_z_reg;

endmodule

// ===== hw/rtl/vbf_checker.sv =====
// Port-level checks of the voxel box fill grid, bound to its top level.
module vbf_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [vbf_pkg::ID_BITS-1:0]            found_id,
    input  logic                                   grid_empty,
    input  logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_min_x,
    input  logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_max_x,
    input  logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_min_y,
    input  logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_max_y,
    input  logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_min_z,
    input  logic signed [vbf_pkg::BOUND_BITS-1:0]  bound_max_z
);
    import vbf_pkg::*;

    // A result beat that is not taken stays valid and holds its found_id.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_id))
        else $error("result beat changed while stalled");

    // Items are worked one at a time, so an accepted beat drops ready.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two cycles in a row");

    // An empty grid reports the sentinel bounds.
    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        grid_empty |-> bound_min_x == BOUND_NONE_MIN && bound_max_x == BOUND_NONE_MAX
                    && bound_min_y == BOUND_NONE_MIN && bound_max_y == BOUND_NONE_MAX
                    && bound_min_z == BOUND_NONE_MIN && bound_max_z == BOUND_NONE_MAX)
        else $error("empty grid with non-sentinel bounds");

    // Once something is written the bounds enclose at least one voxel.
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        !grid_empty |-> bound_min_x <= bound_max_x && bound_min_y <= bound_max_y
                     && bound_min_z <= bound_max_z)
        else $error("bounding box inverted");

endmodule

bind voxel_box_fill_grid vbf_checker u_vbf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found_id    (found_id),
    .grid_empty  (grid_empty),
    .bound_min_x (bound_min_x),
    .bound_max_x (bound_max_x),
    .bound_min_y (bound_min_y),
    .bound_max_y (bound_max_y),
    .bound_min_z (bound_min_z),
    .bound_max_z (bound_max_z)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the voxel box fill grid: directed, back-pressure and random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vbf_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_NOP = 2'd3;
    localparam int VOXELS      = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [MODE_BITS-1:0]         mode;
        logic signed [COORD_BITS-1:0] x_lo;
        logic signed [COORD_BITS-1:0] x_hi;
        logic signed [COORD_BITS-1:0] y_lo;
        logic signed [COORD_BITS-1:0] y_hi;
        logic signed [COORD_BITS-1:0] z_lo;
        logic signed [COORD_BITS-1:0] z_hi;
        logic [ID_BITS-1:0]           obj;
        logic [GRID_BITS-1:0]         qx;
        logic [GRID_BITS-1:0]         qy;
        logic [GRID_BITS-1:0]         qz;
    } grid_cmd_t;

    typedef struct packed {
        logic [ID_BITS-1:0]           found;
        logic                         empty;
        logic signed [BOUND_BITS-1:0] min_x;
        logic signed [BOUND_BITS-1:0] max_x;
        logic signed [BOUND_BITS-1:0] min_y;
        logic signed [BOUND_BITS-1:0] max_y;
        logic signed [BOUND_BITS-1:0] min_z;
        logic signed [BOUND_BITS-1:0] max_z;
    } grid_report_t;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PERIODIC, RX_BURSTY} rx_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [MODE_BITS-1:0] mode = '0;
    logic signed [COORD_BITS-1:0] box_x_low = '0;
    logic signed [COORD_BITS-1:0] box_x_high = '0;
    logic signed [COORD_BITS-1:0] box_y_low = '0;
    logic signed [COORD_BITS-1:0] box_y_high = '0;
    logic signed [COORD_BITS-1:0] box_z_low = '0;
    logic signed [COORD_BITS-1:0] box_z_high = '0;
    logic [ID_BITS-1:0] object_id = '0;
    logic [GRID_BITS-1:0] query_x = '0;
    logic [GRID_BITS-1:0] query_y = '0;
    logic [GRID_BITS-1:0] query_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ID_BITS-1:0] found_id;
    logic grid_empty;
    logic signed [BOUND_BITS-1:0] bound_min_x;
    logic signed [BOUND_BITS-1:0] bound_max_x;
    logic signed [BOUND_BITS-1:0] bound_min_y;
    logic signed [BOUND_BITS-1:0] bound_max_y;
    logic signed [BOUND_BITS-1:0] bound_min_z;
    logic signed [BOUND_BITS-1:0] bound_max_z;

    // Mirror of the grid contents and the bounding box of written voxels.
    logic [ID_BITS-1:0] mirror_voxels [0:VOXELS-1];
    int mirror_min [3];
    int mirror_max [3];
    bit mirror_written;
    int fill_first [3];
    int fill_last [3];

    grid_report_t pending_reports [$];
    grid_report_t got_report;
    grid_report_t want_report;
    int fail_count = 0;
    int cycle_count = 0;
    bit hold_output = 1'b0;
    bit tx_steady = 1'b0;
    int burst_left = 0;

    voxel_box_fill_grid u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .box_x_low   (box_x_low),
        .box_x_high  (box_x_high),
        .box_y_low   (box_y_low),
        .box_y_high  (box_y_high),
        .box_z_low   (box_z_low),
        .box_z_high  (box_z_high),
        .object_id   (object_id),
        .query_x     (query_x),
        .query_y     (query_y),
        .query_z     (query_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found_id    (found_id),
        .grid_empty  (grid_empty),
        .bound_min_x (bound_min_x),
        .bound_max_x (bound_max_x),
        .bound_min_y (bound_min_y),
        .bound_max_y (bound_max_y),
        .bound_min_z (bound_min_z),
        .bound_max_z (bound_max_z)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void clear_mirror();
        foreach (mirror_voxels[i])
        begin
            mirror_voxels[i] = '0;
        end
        for (int a = 0; a < 3; a++)
        begin
            mirror_min[a] = GRID_SIZE;
            mirror_max[a] = -1;
        end
        mirror_written = 1'b0;
    endfunction

    // Low edge rounds half up (floor of lo + 0.5); high edge is ceil of hi + 0.5, minus one.
    function automatic void voxel_span(input logic signed [COORD_BITS-1:0] lo,
                                       input logic signed [COORD_BITS-1:0] hi,
                                       output int first, output int last);
        first = (int'(lo) + HALF) >>> FRAC_BITS;
        last  = (int'(hi) + HALF - 1) >>> FRAC_BITS;
        if (first < 0)
        begin
            first = 0;
        end
        if (last > GRID_SIZE - 1)
        begin
            last = GRID_SIZE - 1;
        end
    endfunction

    function automatic grid_report_t apply_to_mirror(input grid_cmd_t cmd);
        logic signed [COORD_BITS-1:0] lo [3];
        logic signed [COORD_BITS-1:0] hi [3];
        int first [3];
        int last [3];
        grid_report_t rep;
        rep = '0;
        lo = '{cmd.x_lo, cmd.y_lo, cmd.z_lo};
        hi = '{cmd.x_hi, cmd.y_hi, cmd.z_hi};
        case (cmd.mode)
            MODE_CLEAR:
            begin
                clear_mirror();
            end
            MODE_ADD:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    voxel_span(lo[a], hi[a], first[a], last[a]);
                end
                // An id of zero means no object, so such a box changes nothing.
                if (cmd.obj != '0 && first[0] <= last[0] && first[1] <= last[1]
                    && first[2] <= last[2])
                begin
                    for (int x = first[0]; x <= last[0]; x++)
                    begin
                        for (int y = first[1]; y <= last[1]; y++)
                        begin
                            for (int z = first[2]; z <= last[2]; z++)
                            begin
                                mirror_voxels[(x * GRID_SIZE + y) * GRID_SIZE + z] = cmd.obj;
                            end
                        end
                    end
                    for (int a = 0; a < 3; a++)
                    begin
                        if (first[a] < mirror_min[a])
                        begin
                            mirror_min[a] = first[a];
                        end
                        if (last[a] > mirror_max[a])
                        begin
                            mirror_max[a] = last[a];
                        end
                        fill_first[a] = first[a];
                        fill_last[a]  = last[a];
                    end
                    mirror_written = 1'b1;
                end
            end
            MODE_LOOKUP:
            begin
                rep.found = mirror_voxels[(int'(cmd.qx) * GRID_SIZE + int'(cmd.qy)) * GRID_SIZE
                                          + int'(cmd.qz)];
            end
            default:
            begin
            end
        endcase
        rep.empty = !mirror_written;
        rep.min_x = BOUND_BITS'(mirror_min[0]);
        rep.max_x = BOUND_BITS'(mirror_max[0]);
        rep.min_y = BOUND_BITS'(mirror_min[1]);
        rep.max_y = BOUND_BITS'(mirror_max[1]);
        rep.min_z = BOUND_BITS'(mirror_min[2]);
        rep.max_z = BOUND_BITS'(mirror_max[2]);
        return rep;
    endfunction

    function automatic grid_cmd_t make_box(input int x_lo, input int x_hi, input int y_lo,
                                           input int y_hi, input int z_lo, input int z_hi,
                                           input int obj);
        grid_cmd_t cmd;
        cmd      = '0;
        cmd.mode = MODE_ADD;
        cmd.x_lo = COORD_BITS'(x_lo);
        cmd.x_hi = COORD_BITS'(x_hi);
        cmd.y_lo = COORD_BITS'(y_lo);
        cmd.y_hi = COORD_BITS'(y_hi);
        cmd.z_lo = COORD_BITS'(z_lo);
        cmd.z_hi = COORD_BITS'(z_hi);
        cmd.obj  = ID_BITS'(obj);
        return cmd;
    endfunction

    function automatic grid_cmd_t make_query(input int x, input int y, input int z);
        grid_cmd_t cmd;
        cmd      = '0;
        cmd.mode = MODE_LOOKUP;
        cmd.qx   = GRID_BITS'(x);
        cmd.qy   = GRID_BITS'(y);
        cmd.qz   = GRID_BITS'(z);
        return cmd;
    endfunction

    function automatic grid_cmd_t make_op(input logic [MODE_BITS-1:0] op);
        grid_cmd_t cmd;
        cmd      = '0;
        cmd.mode = op;
        return cmd;
    endfunction

    // A coordinate within one voxel either way of the given voxel's lower face.
    function automatic logic signed [COORD_BITS-1:0] coord_near(input int voxel);
        return COORD_BITS'(voxel * (1 << FRAC_BITS) + int'($urandom_range(0, 511)) - 256);
    endfunction

    function automatic grid_cmd_t random_command();
        grid_cmd_t cmd;
        logic signed [COORD_BITS-1:0] lo [3];
        logic signed [COORD_BITS-1:0] hi [3];
        logic signed [COORD_BITS-1:0] swap;
        int pick;
        int start;
        int span;
        int flip_axis;
        cmd.mode = MODE_BITS'($urandom);
        cmd.x_lo = COORD_BITS'($urandom);
        cmd.x_hi = COORD_BITS'($urandom);
        cmd.y_lo = COORD_BITS'($urandom);
        cmd.y_hi = COORD_BITS'($urandom);
        cmd.z_lo = COORD_BITS'($urandom);
        cmd.z_hi = COORD_BITS'($urandom);
        cmd.obj  = ID_BITS'($urandom);
        cmd.qx   = GRID_BITS'($urandom);
        cmd.qy   = GRID_BITS'($urandom);
        cmd.qz   = GRID_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            cmd.mode = MODE_CLEAR;
        end
        else if (pick < 4)
        begin
            cmd.mode = MODE_NOP;
        end
        else if (pick < 50)
        begin
            cmd.mode = MODE_ADD;
            pick = $urandom_range(0, 99);
            // A few boxes keep fully random corners: mostly inverted or huge.
            if (pick >= 5)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    start = int'($urandom_range(0, 35)) - 2;
                    span  = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 31)
                                                         : $urandom_range(0, 3);
                    lo[a] = coord_near(start);
                    hi[a] = coord_near(start + span);
                end
                if (pick < 8)
                begin
                    flip_axis     = $urandom_range(0, 2);
                    swap          = lo[flip_axis];
                    lo[flip_axis] = hi[flip_axis] + COORD_BITS'(512);
                    hi[flip_axis] = swap;
                end
                cmd.x_lo = lo[0];
                cmd.x_hi = hi[0];
                cmd.y_lo = lo[1];
                cmd.y_hi = hi[1];
                cmd.z_lo = lo[2];
                cmd.z_hi = hi[2];
            end
            cmd.obj = ($urandom_range(0, 29) == 0) ? '0 : ID_BITS'($urandom_range(1, 255));
        end
        else
        begin
            cmd.mode = MODE_LOOKUP;
            // Most lookups land in the latest box so that hits are common.
            if (mirror_written && $urandom_range(0, 9) < 6)
            begin
                cmd.qx = GRID_BITS'($urandom_range(fill_first[0], fill_last[0]));
                cmd.qy = GRID_BITS'($urandom_range(fill_first[1], fill_last[1]));
                cmd.qz = GRID_BITS'($urandom_range(fill_first[2], fill_last[2]));
            end
        end
        return cmd;
    endfunction

    // Presents one beat, waits for the handshake and records the expected result.
    task automatic offer_command(input grid_cmd_t cmd);
        int gap;
        in_valid   <= 1'b1;
        mode       <= cmd.mode;
        box_x_low  <= cmd.x_lo;
        box_x_high <= cmd.x_hi;
        box_y_low  <= cmd.y_lo;
        box_y_high <= cmd.y_hi;
        box_z_low  <= cmd.z_lo;
        box_z_high <= cmd.z_hi;
        object_id  <= cmd.obj;
        query_x    <= cmd.qx;
        query_y    <= cmd.qy;
        query_z    <= cmd.qz;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        pending_reports.push_back(apply_to_mirror(cmd));
        @(negedge clk);
        if (!tx_steady)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(0, 24);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_report.found = found_id;
            got_report.empty = grid_empty;
            got_report.min_x = bound_min_x;
            got_report.max_x = bound_max_x;
            got_report.min_y = bound_min_y;
            got_report.max_y = bound_max_y;
            got_report.min_z = bound_min_z;
            got_report.max_z = bound_max_z;
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("unexpected result beat: found_id %0d", found_id);
                end
            end
            else
            begin
                want_report = pending_reports.pop_front();
                if (got_report !== want_report)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("mismatch (exp/act): found_id %0d/%0d grid_empty %0b/%0b",
                                 want_report.found, got_report.found,
                                 want_report.empty, got_report.empty);
                        $display("  min x,y,z %0d,%0d,%0d / %0d,%0d,%0d",
                                 want_report.min_x, want_report.min_y, want_report.min_z,
                                 got_report.min_x, got_report.min_y, got_report.min_z);
                        $display("  max x,y,z %0d,%0d,%0d / %0d,%0d,%0d",
                                 want_report.max_x, want_report.max_y, want_report.max_z,
                                 got_report.max_x, got_report.max_y, got_report.max_z);
                    end
                end
            end
        end
    end

    // Result sink: switches between stall patterns, and holds off on request.
    initial
    begin : output_sink
        rx_style_t style;
        int style_left;
        int stall_left;
        int hold_cnt;
        style      = RX_ALWAYS;
        style_left = 100;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                begin
                    @(negedge clk);
                end
                hold_output = 1'b0;
            end
            if (style_left == 0)
            begin
                style      = rx_style_t'($urandom_range(0, 4));
                style_left = $urandom_range(50, 300);
            end
            style_left--;
            case (style)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_HALF:     out_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:   out_ready <= ($urandom_range(0, 9) != 0);
                RX_PERIODIC: out_ready <= (style_left % 4 != 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(1, 16);
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic test_empty_grid();
        offer_command(make_query(0, 0, 0));
        offer_command(make_query(31, 31, 31));
        offer_command(make_op(MODE_NOP));
    endtask

    // Half-voxel rounding at both box edges, clipping on each side, and boxes that write nothing.
    task automatic test_rounding_and_clipping();
        offer_command(make_box('h007F, 'h0081, 'h0100, 'h0100, 'h0000, 'h0000, 17));
        offer_command(make_query(1, 1, 0));
        offer_command(make_query(2, 1, 0));
        offer_command(make_box(-'h0300, 'h0180, -32768, 'h0080, 'h1E00, 32767, 200));
        offer_command(make_query(0, 0, 31));
        offer_command(make_box('h2000, 'h3000, 0, 'h0100, 0, 'h0100, 5));
        offer_command(make_box(-'h1000, -'h0081, 0, 'h0100, 0, 'h0100, 6));
        offer_command(make_box('h0500, 'h0200, 0, 'h0100, 0, 'h0100, 7));
        offer_command(make_box('h0200, 'h0400, 'h0200, 'h0400, 'h0200, 'h0400, 0));
        offer_command(make_box('h0180, 'h0180, 0, 'h0100, 0, 'h0100, 9));
        offer_command(make_query(2, 2, 2));
        offer_command(make_op(MODE_NOP));
    endtask

    task automatic test_overwrite_and_clear();
        offer_command(make_box(-32768, 32767, -32768, 32767, -32768, 32767, 255));
        offer_command(make_box('h0400, 'h0600, 'h0400, 'h0600, 'h0400, 'h0600, 1));
        offer_command(make_query(5, 5, 5));
        offer_command(make_query(0, 31, 0));
        offer_command(make_query(31, 0, 31));
        offer_command(make_op(MODE_CLEAR));
        offer_command(make_query(5, 5, 5));
    endtask

    // The sink stops taking results for a long stretch while beats keep coming.
    task automatic test_output_backpressure();
        hold_output = 1'b1;
        tx_steady   = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            offer_command(random_command());
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_steady = ($urandom_range(0, 3) == 0);
            end
            offer_command(random_command());
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin
        clear_mirror();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_grid();
        test_rounding_and_clipping();
        test_overwrite_and_clear();
        test_output_backpressure();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (64) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
